// ===== sv/udpc_pkg.sv =====
// Shared types and constants for the UDP pseudo-header checksum block.
`timescale 1ns / 1ps

package udpc_pkg;

  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [7:0] UdpNextHeader = 8'd17;
  localparam logic [7:0] ProtocolReset = 8'd17;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    RegFamilyIsV6   = 3'd0,
    RegSourceAddrHi = 3'd1,
    RegSourceAddrLo = 3'd2,
    RegDestAddrHi   = 3'd3,
    RegDestAddrLo   = 3'd4,
    RegSourcePort   = 3'd5,
    RegDestPort     = 3'd6,
    RegProtocol     = 3'd7
  } udpc_reg_e;

  // One finished datagram payload, handed from the front to the back.
  typedef struct packed {
    logic [15:0]       psum;
    logic [CountW-1:0] count;
  } udpc_entry_t;

  typedef struct packed {
    logic        family_is_v6;
    logic [63:0] source_addr_high;
    logic [63:0] source_addr_low;
    logic [63:0] dest_addr_high;
    logic [63:0] dest_addr_low;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  protocol_number;
  } udpc_cfg_t;

endpackage

// ===== sv/udp_pseudo_header_checksum.sv =====
// Top level of the UDP checksum engine with IPv4 and IPv6 pseudo-header.
//
// Payload bytes enter through a queue-like port: an item is taken at a clock
// edge where push is high and full is low, one item per cycle at full rate.
// The item flagged last_byte_i closes the datagram; byte_present_i low with
// last_byte_i high closes it and adds no byte. Each closing item yields one
// result: checksum, UDP length and an overflow flag.
// Results leave through empty and pop; the oldest result is on the ports
// while empty is low. A result passes a queue of QueueDepth closed datagrams
// between the byte front end and the header arithmetic, then the back's
// input and output registers; full rises only when that queue is full, which
// happens when the receiver holds off pop for long enough. The configuration
// registers are written through cfg_we_i, cfg_index_i and cfg_data_i by the
// user only while the block is idle, which the block does not enforce. Reset
// clears the partial sum, queue and config registers; the protocol register resets to 17.
`timescale 1ns / 1ps

module udp_pseudo_header_checksum #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  payload_byte_i,
  input  logic        byte_present_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] checksum_o,
  output logic [15:0] dgram_length_o,
  output logic        length_overflow_o
);
  import udpc_pkg::*;

  udpc_cfg_t   cfg_q;
  udpc_entry_t front_entry, q_data;
  logic        front_push, q_pop, q_full, q_empty, accept;

  assign full   = q_full;
  assign accept = push & ~q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.family_is_v6     <= 1'b0;
      cfg_q.source_addr_high <= '0;
      cfg_q.source_addr_low  <= '0;
      cfg_q.dest_addr_high   <= '0;
      cfg_q.dest_addr_low    <= '0;
      cfg_q.source_port      <= '0;
      cfg_q.dest_port        <= '0;
      cfg_q.protocol_number  <= ProtocolReset;
    end else if (cfg_we_i) begin
      case (udpc_reg_e'(cfg_index_i))
        RegFamilyIsV6:   cfg_q.family_is_v6     <= cfg_data_i[0];
        RegSourceAddrHi: cfg_q.source_addr_high <= cfg_data_i;
        RegSourceAddrLo: cfg_q.source_addr_low  <= cfg_data_i;
        RegDestAddrHi:   cfg_q.dest_addr_high   <= cfg_data_i;
        RegDestAddrLo:   cfg_q.dest_addr_low    <= cfg_data_i;
        RegSourcePort:   cfg_q.source_port      <= cfg_data_i[15:0];
        RegDestPort:     cfg_q.dest_port        <= cfg_data_i[15:0];
        RegProtocol:     cfg_q.protocol_number  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  udpc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .payload_byte_i (payload_byte_i),
    .byte_present_i (byte_present_i),
    .last_byte_i    (last_byte_i),
    .entry_push_o   (front_push),
    .entry_o        (front_entry)
  );

  udpc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .wdata_i (front_entry),
    .pop_i   (q_pop),
    .rdata_o (q_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  udpc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_empty_i         (q_empty),
    .q_data_i          (q_data),
    .q_pop_o           (q_pop),
    .pop_i             (pop),
    .empty_o           (empty),
    .checksum_o        (checksum_o),
    .dgram_length_o    (dgram_length_o),
    .length_overflow_o (length_overflow_o)
  );

endmodule

// ===== sv/udpc_front.sv =====
// Front part: pairs payload bytes into words and keeps the running payload sum.
`timescale 1ns / 1ps

module udpc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           payload_byte_i,
  input  logic                 byte_present_i,
  input  logic                 last_byte_i,
  output logic                 entry_push_o,
  output udpc_pkg::udpc_entry_t entry_o
);
  import udpc_pkg::*;

  logic [15:0]       sum_q, sum_d;
  logic [CountW-1:0] count_q, count_d, count_inc;
  logic [7:0]        held_q, held_d;
  logic              odd_q, odd_d;
  logic [7:0]        byte_eff;
  logic [15:0]       word;
  logic [16:0]       sum_wide;
  logic [15:0]       sum_fold;

  always_comb begin
    byte_eff = byte_present_i ? payload_byte_i : 8'd0;
    // A held high byte always closes here; on the last item a lone byte is padded.
    if (odd_q) begin
      word = {held_q, byte_eff};
    end else if (last_byte_i) begin
      word = {byte_eff, 8'd0};
    end else begin
      word = 16'd0;
    end
    sum_wide  = {1'b0, sum_q} + {1'b0, word};
    sum_fold  = sum_wide[15:0] + {15'd0, sum_wide[16]};
    count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;

    sum_d   = sum_q;
    count_d = count_q;
    held_d  = held_q;
    odd_d   = odd_q;
    if (accept_i) begin
      if (last_byte_i) begin
        sum_d   = '0;
        count_d = '0;
        held_d  = '0;
        odd_d   = 1'b0;
      end else if (byte_present_i) begin
        count_d = count_inc;
        if (odd_q) begin
          sum_d  = sum_fold;
          held_d = '0;
          odd_d  = 1'b0;
        end else begin
          held_d = payload_byte_i;
          odd_d  = 1'b1;
        end
      end
    end

    entry_push_o   = accept_i & last_byte_i;
    entry_o.psum   = sum_fold;
    entry_o.count  = byte_present_i ? count_inc : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      held_q  <= '0;
      odd_q   <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      held_q  <= held_d;
      odd_q   <= odd_d;
    end
  end

endmodule

// ===== sv/udpc_queue.sv =====
// Short queue of finished payload sums between the front and the back.
`timescale 1ns / 1ps

module udpc_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  udpc_pkg::udpc_entry_t wdata_i,
  input  logic                  pop_i,
  output udpc_pkg::udpc_entry_t rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import udpc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  udpc_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  always_comb begin
    full_o  = (cnt_q == DepthCnt);
    empty_o = (cnt_q == '0);
    do_push = push_i & ~full_o;
    do_pop  = pop_i & ~empty_o;
    rdata_o = mem_q[rptr_q];
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== sv/udpc_back.sv =====
// Back part: adds the pseudo-header and UDP header, folds and holds the result.
`timescale 1ns / 1ps

module udpc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  udpc_pkg::udpc_cfg_t   cfg_i,
  input  logic                  q_empty_i,
  input  udpc_pkg::udpc_entry_t q_data_i,
  output logic                  q_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output logic [15:0]           checksum_o,
  output logic [15:0]           dgram_length_o,
  output logic                  length_overflow_o
);
  import udpc_pkg::*;

  // Word sums of the configuration, refreshed every cycle.
  logic [17:0] src_hi_q, dst_hi_q;
  logic [16:0] src_lo_hi_q, src_lo_lo_q, dst_lo_hi_q, dst_lo_lo_q, ports_q;

  logic        a_valid_q;
  logic [15:0] a_psum_q;
  logic [20:0] a_cfg_q, a_cfg_d;
  logic [17:0] a_lterm_q, a_lterm_d;
  logic [15:0] a_len_q;
  logic        a_ovf_q;
  logic [17:0] len_full;

  logic        out_valid_q;
  logic [15:0] out_chk_q, out_len_q;
  logic        out_ovf_q;

  logic        advance, a_take;
  logic [20:0] b_sum;
  logic [16:0] b_fold1;
  logic [15:0] b_fold2;

  always_ff @(posedge clk_i) begin
    src_hi_q    <= {2'b0, cfg_i.source_addr_high[63:48]} + {2'b0, cfg_i.source_addr_high[47:32]}
                 + {2'b0, cfg_i.source_addr_high[31:16]} + {2'b0, cfg_i.source_addr_high[15:0]};
    dst_hi_q    <= {2'b0, cfg_i.dest_addr_high[63:48]} + {2'b0, cfg_i.dest_addr_high[47:32]}
                 + {2'b0, cfg_i.dest_addr_high[31:16]} + {2'b0, cfg_i.dest_addr_high[15:0]};
    src_lo_hi_q <= {1'b0, cfg_i.source_addr_low[63:48]} + {1'b0, cfg_i.source_addr_low[47:32]};
    src_lo_lo_q <= {1'b0, cfg_i.source_addr_low[31:16]} + {1'b0, cfg_i.source_addr_low[15:0]};
    dst_lo_hi_q <= {1'b0, cfg_i.dest_addr_low[63:48]} + {1'b0, cfg_i.dest_addr_low[47:32]};
    dst_lo_lo_q <= {1'b0, cfg_i.dest_addr_low[31:16]} + {1'b0, cfg_i.dest_addr_low[15:0]};
    ports_q     <= {1'b0, cfg_i.source_port} + {1'b0, cfg_i.dest_port};
  end

  always_comb begin
    advance = ~out_valid_q | pop_i;
    a_take  = ~a_valid_q | advance;
    q_pop_o = a_take & ~q_empty_i;

    len_full = 18'd8 + {1'b0, q_data_i.count};
    // The UDP length appears twice; IPv6 also carries its upper half.
    a_lterm_d = {1'b0, len_full[15:0], 1'b0}
              + (cfg_i.family_is_v6 ? {16'd0, len_full[17:16]} : 18'd0);
    if (cfg_i.family_is_v6) begin
      a_cfg_d = 21'(src_hi_q) + 21'(dst_hi_q) + 21'(src_lo_hi_q) + 21'(src_lo_lo_q)
              + 21'(dst_lo_hi_q) + 21'(dst_lo_lo_q) + 21'(ports_q) + 21'(UdpNextHeader);
    end else begin
      a_cfg_d = 21'(src_lo_lo_q) + 21'(dst_lo_lo_q) + 21'(ports_q)
              + 21'(cfg_i.protocol_number);
    end

    b_sum   = a_cfg_q + 21'(a_psum_q) + 21'(a_lterm_q);
    b_fold1 = {1'b0, b_sum[15:0]} + {12'd0, b_sum[20:16]};
    b_fold2 = b_fold1[15:0] + {15'd0, b_fold1[16]};

    empty_o           = ~out_valid_q;
    checksum_o        = out_chk_q;
    dgram_length_o    = out_len_q;
    length_overflow_o = out_ovf_q;
  end

  always_ff @(posedge clk_i) begin
    if (a_take) begin
      a_psum_q  <= q_data_i.psum;
      a_cfg_q   <= a_cfg_d;
      a_lterm_q <= a_lterm_d;
      a_len_q   <= len_full[15:0];
      a_ovf_q   <= |len_full[17:16];
    end
    if (advance) begin
      out_chk_q <= ~b_fold2;
      out_len_q <= a_len_q;
      out_ovf_q <= a_ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_take) begin
        a_valid_q <= ~q_empty_i;
      end
      if (advance) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

endmodule
